>>> design/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg: shared types, widths and the sine table builder
// Holds the fixed coordinate widths of the oriented rectangle overlap test,
// the stage enable group and the quarter-wave sine generator.
// ----------------------------------------------------------------------------
package obb_pkg;

   // Rotated corner coordinate, edge/normal component and dot product widths.
   localparam int COORD_W = 18;
   localparam int EDGE_W  = 19;
   localparam int PROD_W  = COORD_W + EDGE_W;
   localparam int DOT_W   = PROD_W + 1;
   localparam int NUM_CORNERS = 4;
   localparam int NUM_AXES    = 8;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [EDGE_W-1:0]  edge_type;
   typedef logic signed [DOT_W-1:0]   dot_type;

   // The four corners of one rectangle.
   typedef struct packed {
      coord_type [NUM_CORNERS-1:0] x;
      coord_type [NUM_CORNERS-1:0] y;
   } quad_type;

   // Load enables of the pipeline stages held in the sub-modules.
   typedef struct packed {
      logic s2;
      logic s3;
      logic s5;
      logic s6;
      logic s7;
      logic s8;
   } stage_en_type;

   // round(sin(n deg) * 2^tfb) for n in 0..90, evaluated at elaboration
   // with a Taylor series on a Q30 angle.
   function automatic longint unsigned quarter_sin(input int unsigned n,
                                                   input int unsigned tfb);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned r;
      x    = (64'(n) * 64'd3373259426 + 64'd90) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
      r = (sum + (64'd1 << (29 - tfb))) >> (30 - tfb);
      if (r > (64'd1 << tfb)) begin
         r = 64'd1 << tfb;
      end
      return r;
   endfunction

endpackage

>>> design/obb_trig.sv
// ----------------------------------------------------------------------------
// obb_trig: sine and cosine of a whole-degree angle
// Reduces the angle into one turn, folds it into the first quadrant and
// reads the quarter-wave table; cosine is the sine ninety degrees on.
// ----------------------------------------------------------------------------
module obb_trig #(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic [8:0]                  deg,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
   output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);
   import obb_pkg::*;

   localparam int QW = TRIG_FRAC_BITS + 1;
   localparam int TW = TRIG_FRAC_BITS + 2;

   typedef struct packed {
      logic       neg;
      logic [6:0] idx;
   } fold_type;

   logic [QW-1:0] qsin [0:90];

   for (genvar g = 0; g <= 90; g++) begin : g_tab
      assign qsin[g] = QW'(quarter_sin(g, TRIG_FRAC_BITS));
   end

   function automatic fold_type fold(input logic [9:0] d);
      fold_type f;
      if (d <= 10'd90) begin
         f.neg = 1'b0;
         f.idx = 7'(d);
      end else if (d <= 10'd180) begin
         f.neg = 1'b0;
         f.idx = 7'(10'd180 - d);
      end else if (d <= 10'd270) begin
         f.neg = 1'b1;
         f.idx = 7'(d - 10'd180);
      end else begin
         f.neg = 1'b1;
         f.idx = 7'(10'd360 - d);
      end
      return f;
   endfunction

   logic [9:0]      d_red;
   logic [9:0]      d_cos;
   fold_type        fs;
   fold_type        fc;
   logic [TW-1:0]   qs;
   logic [TW-1:0]   qc;

   always_comb begin
      d_red = (deg >= 9'd360) ? 10'(deg - 9'd360) : 10'(deg);
      d_cos = d_red + 10'd90;
      if (d_cos >= 10'd360) begin
         d_cos = d_cos - 10'd360;
      end
      fs = fold(d_red);
      fc = fold(d_cos);
      qs = TW'(qsin[fs.idx]);
      qc = TW'(qsin[fc.idx]);
      sin_val = fs.neg ? -$signed(qs) : $signed(qs);
      cos_val = fc.neg ? -$signed(qc) : $signed(qc);
   end

endmodule

>>> design/obb_corners.sv
// ----------------------------------------------------------------------------
// obb_corners: rotated corners of one rectangle
// Two stages: the four size-by-trig products, then the rounded offsets
// added to the corner position.
// ----------------------------------------------------------------------------
module obb_corners #(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                             clock,
   input  obb_pkg::stage_en_type            en,
   input  logic signed [15:0]               px,
   input  logic signed [15:0]               py,
   input  logic [14:0]                      w,
   input  logic [14:0]                      h,
   input  logic signed [TRIG_FRAC_BITS+1:0] s,
   input  logic signed [TRIG_FRAC_BITS+1:0] c,
   output obb_pkg::quad_type                corners
);
   import obb_pkg::*;

   localparam int PW = TRIG_FRAC_BITS + 18;
   localparam int SW = PW + 1;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_FRAC_BITS - 1);

   logic signed [PW-1:0] cw_ff, sw_ff, ch_ff, sh_ff;
   logic signed [15:0]   px_ff, py_ff;
   quad_type             corners_ff;

   // Round half up: floor((v + half) / 2^T).
   function automatic coord_type descale(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] t;
      t = (v + HALF) >>> TRIG_FRAC_BITS;
      return COORD_W'(t);
   endfunction

   always_ff @(posedge clock) begin
      if (en.s2) begin
         cw_ff <= PW'(c * $signed({1'b0, w}));
         sw_ff <= PW'(s * $signed({1'b0, w}));
         ch_ff <= PW'(c * $signed({1'b0, h}));
         sh_ff <= PW'(s * $signed({1'b0, h}));
         px_ff <= px;
         py_ff <= py;
      end
   end

   logic signed [SW-1:0] ox [NUM_CORNERS];
   logic signed [SW-1:0] oy [NUM_CORNERS];
   quad_type             corners_in;

   always_comb begin
      ox[0] = '0;
      oy[0] = '0;
      ox[1] = SW'(cw_ff);
      oy[1] = SW'(sw_ff);
      ox[2] = SW'(cw_ff) - SW'(sh_ff);
      oy[2] = SW'(sw_ff) + SW'(ch_ff);
      ox[3] = -SW'(sh_ff);
      oy[3] = SW'(ch_ff);
      for (int i = 0; i < NUM_CORNERS; i++) begin
         corners_in.x[i] = COORD_W'(px_ff) + descale(ox[i]);
         corners_in.y[i] = COORD_W'(py_ff) + descale(oy[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         corners_ff <= corners_in;
      end
   end

   assign corners = corners_ff;

endmodule

>>> design/obb_lane.sv
// ----------------------------------------------------------------------------
// obb_lane: projection and separation test on one axis
// Projects all eight corners on the axis, finds each rectangle's extent
// and flags the axis as separating when the extents do not overlap.
// ----------------------------------------------------------------------------
module obb_lane (
   input  logic                  clock,
   input  obb_pkg::stage_en_type en,
   input  obb_pkg::edge_type     nx,
   input  obb_pkg::edge_type     ny,
   input  obb_pkg::quad_type     pa,
   input  obb_pkg::quad_type     pb,
   output logic                  sep
);
   import obb_pkg::*;

   logic signed [PROD_W-1:0] pax_ff [NUM_CORNERS];
   logic signed [PROD_W-1:0] pay_ff [NUM_CORNERS];
   logic signed [PROD_W-1:0] pbx_ff [NUM_CORNERS];
   logic signed [PROD_W-1:0] pby_ff [NUM_CORNERS];
   dot_type da_ff [NUM_CORNERS];
   dot_type db_ff [NUM_CORNERS];
   dot_type mina_ff, maxa_ff, minb_ff, maxb_ff;
   dot_type mina_in, maxa_in, minb_in, maxb_in;
   logic    sep_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         if (en.s5) begin
            pax_ff[i] <= PROD_W'(nx * pa.x[i]);
            pay_ff[i] <= PROD_W'(ny * pa.y[i]);
            pbx_ff[i] <= PROD_W'(nx * pb.x[i]);
            pby_ff[i] <= PROD_W'(ny * pb.y[i]);
         end
         if (en.s6) begin
            da_ff[i] <= DOT_W'(pax_ff[i]) + DOT_W'(pay_ff[i]);
            db_ff[i] <= DOT_W'(pbx_ff[i]) + DOT_W'(pby_ff[i]);
         end
      end
   end

   always_comb begin
      mina_in = da_ff[0];
      maxa_in = da_ff[0];
      minb_in = db_ff[0];
      maxb_in = db_ff[0];
      for (int i = 1; i < NUM_CORNERS; i++) begin
         if (da_ff[i] < mina_in) mina_in = da_ff[i];
         if (da_ff[i] > maxa_in) maxa_in = da_ff[i];
         if (db_ff[i] < minb_in) minb_in = db_ff[i];
         if (db_ff[i] > maxb_in) maxb_in = db_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s7) begin
         mina_ff <= mina_in;
         maxa_ff <= maxa_in;
         minb_ff <= minb_in;
         maxb_ff <= maxb_in;
      end
      // Touching extents count as separated.
      if (en.s8) begin
         sep_ff <= (maxa_ff <= minb_ff) || (maxb_ff <= mina_ff);
      end
   end

   assign sep = sep_ff;

endmodule

>>> design/obb_pair_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// obb_pair_overlap_test_unit: oriented rectangle pair collision test
// Separating axis test of two rotated rectangles, one pair per item.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | handshake
//  req     | in  | tdata[143:0]: two rectangles (x,y,w,h,deg) | tvalid/tready
//  rsp     | out | tdata[0]: overlap                          | tvalid/tready
//
// A new pair can be accepted in every cycle unless a stalled result has
// backed up every stage. The depth is set by the trig lookup, two corner
// stages, the normals, four stages in each axis lane and the merge register.
// Each stage holds an item until the next stage frees up, so bubbles fill in
// and a stalled result only backs up the stages behind it.
// Reset clears the stage valid flags only; the data registers are not reset.
// ----------------------------------------------------------------------------
module obb_pair_overlap_test_unit #(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0 up: ax[15:0], ay[15:0], aw[14:0], ah[14:0], a_deg[8:0],
   // bx[15:0], by[15:0], bw[14:0], bh[14:0], b_deg[8:0], two zero pad bits.
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0 up: overlap, seven zero pad bits.
   output logic [7:0]   rsp_tdata
);
   import obb_pkg::*;

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int NSTAGE = 9;

   // Per-stage handshake: a stage can load when it is empty or its
   // content moves on in the same cycle.
   logic [NSTAGE:1]   v_ff;
   logic [NSTAGE:1]   v_in;
   logic [NSTAGE+1:1] rdy;
   stage_en_type      en;

   always_comb begin
      rdy[NSTAGE+1] = rsp_tready;
      for (int k = NSTAGE; k >= 1; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      v_in[1] = rdy[1] ? req_tvalid : v_ff[1];
      for (int k = 2; k <= NSTAGE; k++) begin
         v_in[k] = rdy[k] ? v_ff[k-1] : v_ff[k];
      end
      en.s2 = rdy[2];
      en.s3 = rdy[3];
      en.s5 = rdy[5];
      en.s6 = rdy[6];
      en.s7 = rdy[7];
      en.s8 = rdy[8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = rdy[1];
   assign rsp_tvalid = v_ff[NSTAGE];

   // Unpack the incoming item.
   logic signed [15:0] ax, ay, bx, by;
   logic [14:0]        aw, ah, bw, bh;
   logic [8:0]         a_deg, b_deg;

   assign ax    = req_tdata[15:0];
   assign ay    = req_tdata[31:16];
   assign aw    = req_tdata[46:32];
   assign ah    = req_tdata[61:47];
   assign a_deg = req_tdata[70:62];
   assign bx    = req_tdata[86:71];
   assign by    = req_tdata[102:87];
   assign bw    = req_tdata[117:103];
   assign bh    = req_tdata[132:118];
   assign b_deg = req_tdata[141:133];

   // Stage 1: sine and cosine of both angles.
   logic signed [TW-1:0] sa, ca, sb, cb;
   logic signed [TW-1:0] sa_ff, ca_ff, sb_ff, cb_ff;
   logic signed [15:0]   ax_ff, ay_ff, bx_ff, by_ff;
   logic [14:0]          aw_ff, ah_ff, bw_ff, bh_ff;

   obb_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_a (
      .deg(a_deg), .sin_val(sa), .cos_val(ca)
   );
   obb_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_b (
      .deg(b_deg), .sin_val(sb), .cos_val(cb)
   );

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         sa_ff <= sa;
         ca_ff <= ca;
         sb_ff <= sb;
         cb_ff <= cb;
         ax_ff <= ax;
         ay_ff <= ay;
         bx_ff <= bx;
         by_ff <= by;
         aw_ff <= aw;
         ah_ff <= ah;
         bw_ff <= bw;
         bh_ff <= bh;
      end
   end

   // Stages 2 and 3: rotated corners of each rectangle.
   quad_type qa, qb;

   obb_corners #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_corners_a (
      .clock(clock), .en(en), .px(ax_ff), .py(ay_ff), .w(aw_ff), .h(ah_ff),
      .s(sa_ff), .c(ca_ff), .corners(qa)
   );
   obb_corners #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_corners_b (
      .clock(clock), .en(en), .px(bx_ff), .py(by_ff), .w(bw_ff), .h(bh_ff),
      .s(sb_ff), .c(cb_ff), .corners(qb)
   );

   // Stage 4: left normals of all edges. Rectangle a's edges give axes 0 to 3,
   // rectangle b's give axes 4 to 7. A zero-length edge gives a zero normal,
   // which its lane reports as separating.
   edge_type nx_in [NUM_AXES];
   edge_type ny_in [NUM_AXES];
   edge_type nx_ff [NUM_AXES];
   edge_type ny_ff [NUM_AXES];
   quad_type qa_ff, qb_ff;

   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         nx_in[i] = EDGE_W'(qa.y[i]) - EDGE_W'(qa.y[(i + 1) % NUM_CORNERS]);
         ny_in[i] = EDGE_W'(qa.x[(i + 1) % NUM_CORNERS]) - EDGE_W'(qa.x[i]);
         nx_in[i + NUM_CORNERS] =
            EDGE_W'(qb.y[i]) - EDGE_W'(qb.y[(i + 1) % NUM_CORNERS]);
         ny_in[i + NUM_CORNERS] =
            EDGE_W'(qb.x[(i + 1) % NUM_CORNERS]) - EDGE_W'(qb.x[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         qa_ff <= qa;
         qb_ff <= qb;
      end
   end

   // Stages 5 to 8: one lane per axis.
   logic [NUM_AXES-1:0] sep;

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      obb_lane u_lane (
         .clock(clock), .en(en), .nx(nx_ff[g]), .ny(ny_ff[g]),
         .pa(qa_ff), .pb(qb_ff), .sep(sep[g])
      );
   end

   // Stage 9: the pair collides when no lane found a separating axis.
   logic overlap_ff;

   always_ff @(posedge clock) begin
      if (rdy[NSTAGE]) begin
         overlap_ff <= ~|sep;
      end
   end

   assign rsp_tdata = {7'b0, overlap_ff};

endmodule

>>> design/obb_checker.sv
// ----------------------------------------------------------------------------
// obb_checker: port-level checks of the overlap test unit
// Watches the handshakes and the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module obb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // Nothing is left in flight after a reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // The input side only backs up when a result is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a waiting result");

   // A held result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("waiting result changed");

   // Pad bits of the result stay zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:1] == 7'b0))
      else $error("result pad bits set");

endmodule

bind obb_pair_overlap_test_unit obb_checker u_obb_checker (.*);
